// ===== rtl/block_mean_luma_retarget_unit_assert.svh =====
// Assertion macros used by the block's top-level RTL
`ifndef BLOCK_MEAN_LUMA_RETARGET_UNIT_ASSERT_SVH
`define BLOCK_MEAN_LUMA_RETARGET_UNIT_ASSERT_SVH

// same-cycle implication
`define BLMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLMR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/blmr_pkg.sv =====
package blmr_pkg;

    localparam int GROUP_SIZE_DEF = 8;
    localparam logic [15:0] LUMA_MAX = 16'hFF00;
    localparam int DELTA_W = 18;

    localparam logic [1:0] REG_TOLERANCE    = 2'd0;
    localparam logic [1:0] REG_MAX_PASSES   = 2'd1;
    localparam logic [1:0] REG_REACH_MARGIN = 2'd2;

    localparam logic [7:0] TOLERANCE_RST    = 8'd25;
    localparam logic [3:0] MAX_PASSES_RST   = 4'd4;
    localparam logic [9:0] REACH_MARGIN_RST = 10'd256;

    typedef struct packed {
        logic capture;
        logic ld_rd;
        logic ld_wr;
        logic div_mean;
        logic div_delta;
        logic take_mean;
        logic take_delta;
        logic q_clear;
        logic pass_clear;
        logic ptr_clear;
        logic sw_rd;
        logic sw_wr;
        logic em_rd;
        logic put_one;
        logic put_sample;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic load_bad;
        logic adj_ignored;
        logic div_done;
        logic q_last;
        logic ptr_last;
        logic more_passes;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/block_mean_luma_retarget_unit.sv =====
// Block mean luma retarget. Holds a GROUP_SIZE x GROUP_SIZE block of 8.8 luma
// samples and the mean of the present ones. A load word runs decode, a
// read-modify-write of the sample store, a 22-step serial divide for the mean
// at GROUP_SIZE 8 (with a start and a take) and one result. An ignored word
// runs decode and one result. An adjust word runs, per pass, the ring steps
// ((GROUP_SIZE+1)/2 steps, by reciprocal multiply), a sweep of the single-port
// sample store that reads and writes each sample, one mean divide and a check.
// It then emits all samples, each read from the store and then put out. The
// serial mean divider and the one store port set the pace; a stalled result
// holds the unit.
// Only one word is worked on at a time.
`include "block_mean_luma_retarget_unit_assert.svh"

module block_mean_luma_retarget_unit #(
    parameter int GROUP_SIZE = blmr_pkg::GROUP_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // column, row, luma, present, target_mean, zero fill
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // sample_index, sample_luma, sample_present,
                                  // block_mean, mean_valid, reached, zero fill
    output logic        m_tuser,  // ignored
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    blmr_pkg::cmd_t cmd;
    blmr_pkg::sts_t sts;

    logic [5:0]  out_index;
    logic [15:0] out_luma, out_mean;
    logic        out_present, out_mean_valid, out_reached;

    blmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    blmr_dp #(.GROUP_SIZE(GROUP_SIZE)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_kind        (s_tuser),
        .in_column      (s_tdata[2:0]),
        .in_row         (s_tdata[5:3]),
        .in_luma        (s_tdata[21:6]),
        .in_present     (s_tdata[22]),
        .in_target      (s_tdata[40:23]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_index      (out_index),
        .out_luma       (out_luma),
        .out_present    (out_present),
        .out_mean       (out_mean),
        .out_mean_valid (out_mean_valid),
        .out_reached    (out_reached),
        .out_ignored    (m_tuser),
        .out_last       (m_tlast)
    );

    assign m_tdata = {7'b0, out_reached, out_mean_valid, out_mean, out_present,
                      out_luma, out_index};

    `BLMR_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "word taken while busy")
    `BLMR_ASSERT_IMP(a_ignored_single, m_tvalid && m_tuser,
                     m_tlast && m_tdata[5:0] == 6'd0, "ignored word not a lone result")
    `BLMR_ASSERT_IMP(a_reach_needs_mean, m_tvalid && !m_tdata[39], !m_tdata[40],
                     "reached without a mean")
    `BLMR_ASSERT_IMP(a_absent_zero, m_tvalid && !m_tdata[22], m_tdata[21:6] == 16'd0,
                     "absent sample with nonzero luma")

endmodule

// ===== rtl/blmr_div.sv =====
module blmr_div #(
    parameter int N = 22,
    parameter int D = 7
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic [N-1:0] quotient,
    output logic         done
);

    localparam int CW = $clog2(N + 1);

    logic [D:0]    rem_reg, rem_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [D:0]    shifted;

    assign shifted = {rem_reg[D-1:0], quo_reg[N-1]};

    always_comb begin
        if (shifted >= {1'b0, den_reg}) begin
            rem_next = shifted - {1'b0, den_reg};
            quo_next = {quo_reg[N-2:0], 1'b1};
        end else begin
            rem_next = shifted;
            quo_next = {quo_reg[N-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(N);
            rem_reg  <= '0;
            quo_reg  <= dividend;
            den_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/blmr_ctrl.sv =====
module blmr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  blmr_pkg::sts_t sts,
    output blmr_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_LD_RD, ST_LD_WR, ST_MDIV, ST_MWAIT, ST_MTAKE,
        ST_DQ_DIV, ST_DQ_TAKE, ST_SW_RD, ST_SW_WR, ST_CHECK,
        ST_EM_RD, ST_EM_PUT, ST_PUT_ONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!sts.kind) begin
                    state_next = sts.load_bad ? ST_PUT_ONE : ST_LD_RD;
                end else if (sts.adj_ignored) begin
                    state_next = ST_PUT_ONE;
                end else begin
                    cmd.pass_clear = 1'b1;
                    cmd.q_clear    = 1'b1;
                    state_next     = ST_DQ_DIV;
                end
            end
            ST_LD_RD: begin
                cmd.ld_rd  = 1'b1;
                state_next = ST_LD_WR;
            end
            ST_LD_WR: begin
                cmd.ld_wr  = 1'b1;
                state_next = ST_MDIV;
            end
            ST_MDIV: begin
                cmd.div_mean = 1'b1;
                state_next   = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (sts.div_done) state_next = ST_MTAKE;
            end
            ST_MTAKE: begin
                cmd.take_mean = 1'b1;
                state_next    = sts.kind ? ST_CHECK : ST_PUT_ONE;
            end
            ST_DQ_DIV: begin
                cmd.div_delta = 1'b1;
                state_next    = ST_DQ_TAKE;
            end
            ST_DQ_TAKE: begin
                cmd.take_delta = 1'b1;
                if (sts.q_last) begin
                    cmd.ptr_clear = 1'b1;
                    state_next    = ST_SW_RD;
                end else begin
                    state_next = ST_DQ_DIV;
                end
            end
            ST_SW_RD: begin
                cmd.sw_rd  = 1'b1;
                state_next = ST_SW_WR;
            end
            ST_SW_WR: begin
                cmd.sw_wr  = 1'b1;
                state_next = sts.ptr_last ? ST_MDIV : ST_SW_RD;
            end
            ST_CHECK: begin
                if (sts.more_passes) begin
                    cmd.q_clear = 1'b1;
                    state_next  = ST_DQ_DIV;
                end else begin
                    cmd.ptr_clear = 1'b1;
                    state_next    = ST_EM_RD;
                end
            end
            ST_EM_RD: begin
                cmd.em_rd  = 1'b1;
                state_next = ST_EM_PUT;
            end
            ST_EM_PUT: begin
                if (sts.out_free) begin
                    cmd.put_sample = 1'b1;
                    state_next     = sts.ptr_last ? ST_IDLE : ST_EM_RD;
                end
            end
            ST_PUT_ONE: begin
                if (sts.out_free) begin
                    cmd.put_one = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE) && !cmd.capture;
        end
    end

    assign s_tready = ready_reg;

endmodule

// ===== rtl/blmr_dp.sv =====
module blmr_dp #(
    parameter int GROUP_SIZE = blmr_pkg::GROUP_SIZE_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  blmr_pkg::cmd_t cmd,
    output blmr_pkg::sts_t sts,
    input  logic           in_kind,
    input  logic [2:0]     in_column,
    input  logic [2:0]     in_row,
    input  logic [15:0]    in_luma,
    input  logic           in_present,
    input  logic [17:0]    in_target,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [9:0]     cfg_wdata,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [5:0]     out_index,
    output logic [15:0]    out_luma,
    output logic           out_present,
    output logic [15:0]    out_mean,
    output logic           out_mean_valid,
    output logic           out_reached,
    output logic           out_ignored,
    output logic           out_last
);

    localparam int CELLS = GROUP_SIZE * GROUP_SIZE;
    localparam int PW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int QMAX  = (GROUP_SIZE + 1) / 2;
    localparam int QW    = $clog2(QMAX + 1);
    localparam int QIW   = $clog2(QMAX);
    localparam int SUM_W = $clog2(CELLS * 65280 + 1);
    localparam int NUM_W = $clog2(8 * QMAX * 65280 + GROUP_SIZE + 1);
    localparam int DV_W  = SUM_W;
    localparam int DW    = blmr_pkg::DELTA_W;
    localparam int RSH   = NUM_W + $clog2(2 * GROUP_SIZE);
    localparam longint unsigned RECIP = ((64'd1 << RSH) + 64'(2 * GROUP_SIZE) - 64'd1)
                                        / 64'(2 * GROUP_SIZE);
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PRW   = NUM_W + RW;

    logic [15:0] mem [CELLS];
    logic [15:0] rd_reg;

    logic              kind_reg, pres_reg;
    logic [2:0]        col_reg, row_reg;
    logic [15:0]       luma_reg;
    logic [17:0]       target_reg;
    logic [7:0]        tol_reg;
    logic [3:0]        maxp_reg;
    logic [9:0]        margin_reg;
    logic [CELLS-1:0]  present_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]     cnt_reg;
    logic [15:0]       mean_reg;
    logic [3:0]        pass_reg;
    logic [QW-1:0]     q_reg;
    logic [DW-1:0]     delta_reg [QMAX];
    logic [PW-1:0]     ptr_reg;
    logic [2:0]        x_reg, y_reg;
    logic [NUM_W-1:0]  num_reg;

    logic [6:0]        lidx_full;
    logic [PW-1:0]     lidx;
    logic [19:0]       dist_w, absd;
    logic              dist_neg, mean_known, reached_w;
    logic [3:0]        limit;
    logic [15:0]       new_luma, old_luma;
    logic [DV_W-1:0]   div_a, div_q;
    logic [CW-1:0]     div_b;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  num_w;
    logic [PRW-1:0]    prod_w;
    logic [QW-1:0]     qx, qy, qs;
    logic [DW-1:0]     dsel;
    logic [19:0]       vs;
    logic [15:0]       v_clamped;
    logic              m_valid_reg;

    assign lidx_full  = 7'(row_reg) * 7'(GROUP_SIZE) + 7'(col_reg);
    assign lidx       = lidx_full[PW-1:0];
    assign dist_w     = {{2{target_reg[17]}}, target_reg} - {4'b0, mean_reg};
    assign dist_neg   = dist_w[19];
    assign absd       = dist_neg ? (20'd0 - dist_w) : dist_w;
    assign mean_known = (cnt_reg != '0);
    assign reached_w  = mean_known && (absd <= {10'b0, margin_reg});
    assign limit      = (maxp_reg == 4'd0) ? 4'd1 : maxp_reg;
    assign new_luma   = !pres_reg ? 16'd0 :
                        (luma_reg > blmr_pkg::LUMA_MAX) ? blmr_pkg::LUMA_MAX : luma_reg;
    assign old_luma   = present_reg[lidx] ? rd_reg : 16'd0;

    assign num_w = NUM_W'({absd[15:0], 3'b000}) * NUM_W'(q_reg) + NUM_W'(GROUP_SIZE);
    assign prod_w = PRW'(num_reg) * PRW'(RECIP);
    assign div_start = cmd.div_mean;
    assign div_a = sum_reg;
    assign div_b = cnt_reg;

    assign qx   = (2 * int'(x_reg) < GROUP_SIZE) ? QW'(x_reg + 3'd1)
                                                 : QW'(GROUP_SIZE - int'(x_reg));
    assign qy   = (2 * int'(y_reg) < GROUP_SIZE) ? QW'(y_reg + 3'd1)
                                                 : QW'(GROUP_SIZE - int'(y_reg));
    assign qs   = (qx < qy) ? qx : qy;
    assign dsel = delta_reg[QIW'(qs - QW'(1))];
    assign vs   = dist_neg ? ({4'b0, rd_reg} - {{(20 - DW){1'b0}}, dsel})
                           : ({4'b0, rd_reg} + {{(20 - DW){1'b0}}, dsel});
    assign v_clamped = vs[19] ? 16'd0 :
                       (vs > {4'b0, blmr_pkg::LUMA_MAX}) ? blmr_pkg::LUMA_MAX : vs[15:0];

    blmr_div #(.N(DV_W), .D(CW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.ld_wr) mem[lidx] <= new_luma;
        else if (cmd.sw_wr && present_reg[ptr_reg]) mem[ptr_reg] <= v_clamped;
        if (cmd.ld_rd) rd_reg <= mem[lidx];
        else if (cmd.sw_rd || cmd.em_rd) rd_reg <= mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= in_kind;
            col_reg    <= in_column;
            row_reg    <= in_row;
            luma_reg   <= in_luma;
            pres_reg   <= in_present;
            target_reg <= in_target;
        end
        if (cmd.div_delta) num_reg <= num_w;
        if (cmd.take_delta) delta_reg[QIW'(q_reg - QW'(1))] <= DW'(prod_w >> RSH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= blmr_pkg::TOLERANCE_RST;
            maxp_reg    <= blmr_pkg::MAX_PASSES_RST;
            margin_reg  <= blmr_pkg::REACH_MARGIN_RST;
            present_reg <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            mean_reg    <= '0;
            pass_reg    <= '0;
            q_reg       <= '0;
            ptr_reg     <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    blmr_pkg::REG_TOLERANCE:    tol_reg    <= cfg_wdata[7:0];
                    blmr_pkg::REG_MAX_PASSES:   maxp_reg   <= cfg_wdata[3:0];
                    blmr_pkg::REG_REACH_MARGIN: margin_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.ld_wr) begin
                present_reg[lidx] <= pres_reg;
                sum_reg <= sum_reg - SUM_W'(old_luma) + SUM_W'(new_luma);
                cnt_reg <= cnt_reg - CW'(present_reg[lidx]) + CW'(pres_reg);
            end
            if (cmd.take_mean) begin
                mean_reg <= mean_known ? div_q[15:0] : 16'd0;
                if (kind_reg) pass_reg <= pass_reg + 4'd1;
            end
            if (cmd.pass_clear) pass_reg <= '0;
            if (cmd.q_clear) q_reg <= QW'(1);
            else if (cmd.take_delta) q_reg <= q_reg + QW'(1);
            if (cmd.ptr_clear) begin
                ptr_reg <= '0;
                x_reg   <= '0;
                y_reg   <= '0;
                if (cmd.take_delta) sum_reg <= '0;
            end else if (cmd.sw_wr || cmd.put_sample) begin
                ptr_reg <= ptr_reg + PW'(1);
                if (x_reg == 3'(GROUP_SIZE - 1)) begin
                    x_reg <= '0;
                    y_reg <= y_reg + 3'd1;
                end else begin
                    x_reg <= x_reg + 3'd1;
                end
                if (cmd.sw_wr && present_reg[ptr_reg]) sum_reg <= sum_reg + SUM_W'(v_clamped);
            end
            if (cmd.put_one || cmd.put_sample) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put_one) begin
            out_index      <= '0;
            out_luma       <= '0;
            out_present    <= 1'b0;
            out_mean       <= mean_reg;
            out_mean_valid <= mean_known;
            out_reached    <= kind_reg && reached_w;
            out_ignored    <= kind_reg ? sts.adj_ignored : sts.load_bad;
            out_last       <= 1'b1;
        end else if (cmd.put_sample) begin
            out_index      <= 6'(ptr_reg);
            out_luma       <= present_reg[ptr_reg] ? rd_reg : 16'd0;
            out_present    <= present_reg[ptr_reg];
            out_mean       <= mean_reg;
            out_mean_valid <= mean_known;
            out_reached    <= reached_w;
            out_ignored    <= 1'b0;
            out_last       <= (ptr_reg == PW'(CELLS - 1));
        end
    end

    assign m_tvalid = m_valid_reg;

    always_comb begin
        sts             = '0;
        sts.kind        = kind_reg;
        sts.load_bad    = (lidx_full >= 7'(CELLS));
        sts.adj_ignored = target_reg[17] || (target_reg[16:0] > {1'b0, blmr_pkg::LUMA_MAX})
                          || (mean_known && target_reg == {2'b0, mean_reg});
        sts.div_done    = div_done;
        sts.q_last      = (q_reg == QW'(QMAX));
        sts.ptr_last    = (ptr_reg == PW'(CELLS - 1));
        sts.more_passes = (absd > {12'b0, tol_reg}) && (pass_reg < limit);
        sts.out_free    = !m_valid_reg || m_tready;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int SIDE = 8;
    localparam int CELLS = SIDE * SIDE;
    localparam int RANDOM_WORDS = 450;

    typedef struct packed {
        logic [5:0]  sample_index;
        logic [15:0] sample_luma;
        logic        sample_present;
        logic [15:0] block_mean;
        logic        mean_valid;
        logic        reached;
        logic        ignored;
        logic        last;
    } result_t;

    typedef struct {
        logic        kind;
        logic [2:0]  column;
        logic [2:0]  row;
        logic [15:0] luma;
        logic        present;
        logic [17:0] target;
        logic        typed;
        result_t     want;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_wdata = '0;

    block_mean_luma_retarget_unit DUT (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    logic [7:0]  tol_q;
    logic [3:0]  passes_q;
    logic [9:0]  margin_q;
    logic [15:0] luma_q [CELLS];
    logic        pres_q [CELLS];
    logic [15:0] mean_q;
    logic        known_q;

    result_t expected_results[$];
    int mismatches = 0;
    int words_done = 0;

    function automatic void update_mean();
        int unsigned sum, cnt;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < CELLS; i++)
            if (pres_q[i]) begin
                sum += luma_q[i];
                cnt++;
            end
        mean_q = cnt ? 16'(sum / cnt) : 16'd0;
        known_q = cnt != 0;
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic result_t one_result(logic r, logic ign);
        result_t o;
        o = '0;
        o.block_mean = mean_q;
        o.mean_valid = known_q;
        o.reached = r;
        o.ignored = ign;
        o.last = 1;
        return o;
    endfunction

    function automatic void predict_word(logic kind, logic [2:0] col, logic [2:0] rw,
                                         logic [15:0] lum, logic pres, logic [17:0] traw);
        longint target, gap, mag, v;
        int unsigned idx, limit, done;
        int qx, qy, q;
        logic r;
        result_t o;
        target = longint'($signed(traw));
        if (kind == 0) begin
            idx = rw * SIDE + col;
            if (idx >= CELLS) begin
                expected_results.push_back(one_result(0, 1));
                return;
            end
            luma_q[idx] = pres ? (lum > blmr_pkg::LUMA_MAX ? blmr_pkg::LUMA_MAX : lum)
                               : 16'd0;
            pres_q[idx] = pres;
            update_mean();
            expected_results.push_back(one_result(0, 0));
            return;
        end
        if (target < 0 || target > blmr_pkg::LUMA_MAX || (known_q && target == mean_q)) begin
            r = known_q && magnitude(target - mean_q) <= margin_q;
            expected_results.push_back(one_result(r, 1));
            return;
        end
        limit = passes_q == 0 ? 1 : passes_q;
        done = 0;
        gap = target - mean_q;
        do begin
            for (int y = 0; y < SIDE; y++)
                for (int x = 0; x < SIDE; x++) begin
                    qx = (2 * x < SIDE) ? x + 1 : SIDE - x;
                    qy = (2 * y < SIDE) ? y + 1 : SIDE - y;
                    q = qx < qy ? qx : qy;
                    if (pres_q[y * SIDE + x]) begin
                        mag = magnitude(gap) * 4 * q;
                        mag = (2 * mag + SIDE) / (2 * SIDE);
                        v = longint'(luma_q[y * SIDE + x]) + (gap < 0 ? -mag : mag);
                        if (v < 0) v = 0;
                        if (v > blmr_pkg::LUMA_MAX) v = blmr_pkg::LUMA_MAX;
                        luma_q[y * SIDE + x] = 16'(v);
                    end
                end
            update_mean();
            done++;
            gap = target - mean_q;
        end while (magnitude(gap) > tol_q && done < limit);
        r = known_q && magnitude(gap) <= margin_q;
        for (int i = 0; i < CELLS; i++) begin
            o = one_result(r, 0);
            o.sample_index = 6'(i);
            o.sample_luma = luma_q[i];
            o.sample_present = pres_q[i];
            o.last = i == CELLS - 1;
            expected_results.push_back(o);
        end
    endfunction

    task automatic write_reg(logic [1:0] index, logic [9:0] value);
        cfg_we <= 1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 0;
        case (index)
            blmr_pkg::REG_TOLERANCE:    tol_q = value[7:0];
            blmr_pkg::REG_MAX_PASSES:   passes_q = value[3:0];
            blmr_pkg::REG_REACH_MARGIN: margin_q = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic send_word(row_t w);
        int pause;
        pause = $urandom_range(0, 4);
        if (pause != 0) begin
            s_tvalid <= 0;
            repeat (pause) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= w.kind;
        s_tdata <= {7'd0, w.target, w.present, w.luma, w.row, w.column};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (w.typed) begin
            predict_word(w.kind, w.column, w.row, w.luma, w.present, w.target);
            void'(expected_results.pop_back());
            expected_results.push_back(w.want);
        end else begin
            predict_word(w.kind, w.column, w.row, w.luma, w.present, w.target);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (400) @(negedge aclk);
    endtask

    always begin
        int pause;
        pause = $urandom_range(0, 4);
        if (pause != 0) begin
            m_tready <= 0;
            repeat (pause) @(negedge aclk);
        end
        m_tready <= 1;
        do @(posedge aclk); while (!m_tvalid);
        @(negedge aclk);
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[5:0], m_tdata[21:6], m_tdata[22], m_tdata[38:23],
                   m_tdata[39], m_tdata[40], m_tuser, m_tlast};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    function automatic row_t make_row(logic kind, int col, int rw, int lum, int pres,
                                      int target, logic typed = 0,
                                      result_t want = '0);
        row_t w;
        w.kind = kind;
        w.column = 3'(col);
        w.row = 3'(rw);
        w.luma = 16'(lum);
        w.present = pres[0];
        w.target = 18'(target);
        w.typed = typed;
        w.want = want;
        return w;
    endfunction

    task automatic random_phase(int count);
        row_t w;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8)
                w = make_row(0, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 65280),
                             $urandom_range(0, 5) != 0, $urandom());
            else
                w = make_row(1, $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom_range(0, 7) == 0 ? $urandom()
                                                       : $urandom_range(0, 65280));
            send_word(w);
        end
    endtask

    initial begin
        row_t table_rows[$];
        result_t r;
        tol_q = blmr_pkg::TOLERANCE_RST;
        passes_q = blmr_pkg::MAX_PASSES_RST;
        margin_q = blmr_pkg::REACH_MARGIN_RST;
        for (int i = 0; i < CELLS; i++) begin
            luma_q[i] = 0;
            pres_q[i] = 0;
        end
        mean_q = 0;
        known_q = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        r = '0; r.ignored = 1; r.last = 1;
        table_rows.push_back(make_row(1, 0, 0, 0, 0, 1000, 0));
        table_rows.push_back(make_row(1, 0, 0, 0, 0, -1, 1, r));
        table_rows.push_back(make_row(1, 7, 7, 16'hFFFF, 1, 131071, 1, r));
        table_rows.push_back(make_row(1, 0, 0, 0, 0, -65536, 1, r));
        r = '0; r.block_mean = 16'hFF00; r.mean_valid = 1; r.last = 1;
        table_rows.push_back(make_row(0, 7, 7, 16'hFFFF, 1, 0, 1, r));
        table_rows.push_back(make_row(0, 0, 0, 0, 1, 0));
        table_rows.push_back(make_row(0, 3, 4, 65280, 1, 0));
        table_rows.push_back(make_row(1, 0, 0, 0, 0, 65280));
        table_rows.push_back(make_row(1, 0, 0, 0, 0, 0));
        table_rows.push_back(make_row(0, 0, 0, 0, 0, 0));
        table_rows.push_back(make_row(1, 0, 0, 0, 0, 128 * 256));
        table_rows.push_back(make_row(0, 5, 2, 12345, 1, 0));
        table_rows.push_back(make_row(0, 5, 2, 12345, 1, 0));
        foreach (table_rows[k]) send_word(table_rows[k]);
        drain();

        write_reg(blmr_pkg::REG_TOLERANCE, 10'd0);
        write_reg(blmr_pkg::REG_MAX_PASSES, 10'd15);
        write_reg(blmr_pkg::REG_REACH_MARGIN, 10'd0);
        send_word(make_row(1, 0, 0, 0, 0, 100 * 256));
        random_phase(RANDOM_WORDS / 3);
        drain();

        write_reg(blmr_pkg::REG_TOLERANCE, 10'd255);
        write_reg(blmr_pkg::REG_MAX_PASSES, 10'd1);
        write_reg(blmr_pkg::REG_REACH_MARGIN, 10'd1023);
        random_phase(RANDOM_WORDS / 3);
        drain();

        write_reg(blmr_pkg::REG_TOLERANCE, 10'($urandom_range(0, 255)));
        write_reg(blmr_pkg::REG_MAX_PASSES, 10'd0);
        write_reg(blmr_pkg::REG_REACH_MARGIN, 10'($urandom_range(0, 1023)));
        random_phase(RANDOM_WORDS / 3);
        drain();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
